// ===== rtl/core/trial_division_prime_test_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the trial division prime test.
// Each macro expects signals named clk and arst_n in the using module.
// ---------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define TDPT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdpt: assertion failed");

// Antecedent implies consequent in the next cycle.
`define TDPT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdpt: assertion failed");

`endif

// ===== rtl/core/tdpt_pkg.sv =====
// ---------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants of the trial division prime test.
// ---------------------------------------------------------------------------
package tdpt_pkg;

	localparam int NUMBER_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture a new number, divisor back to two
		logic init_div;  // start a serial remainder
		logic div_step;  // one remainder bit
		logic advance;   // next candidate divisor
		logic set_res;   // record the verdict
		logic res_val;
		logic publish;   // move verdict to the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic below_two; // number below two
		logic sq_gt;     // divisor squared exceeds number
		logic cnt_last;  // last remainder bit this cycle
		logic rem_zero;  // remainder after this step is zero
	} sts_t;

endpackage

// ===== rtl/core/tdpt_datapath.sv =====
// ---------------------------------------------------------------------------
// tdpt_datapath
// Number, divisor, running square and a bit-serial restoring remainder unit.
// ---------------------------------------------------------------------------
module tdpt_datapath #(
	parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [NUMBER_WIDTH-1:0] number,
	input  tdpt_pkg::cmd_t          cmd,
	output tdpt_pkg::sts_t          sts,
	output logic                    is_prime
);
	import tdpt_pkg::*;

	localparam int DW = NUMBER_WIDTH / 2 + 2;
	localparam int SW = 2 * DW;
	localparam int CW = $clog2(NUMBER_WIDTH);

	logic [NUMBER_WIDTH-1:0] num_q;
	logic [NUMBER_WIDTH-1:0] sh_q;
	logic [DW-1:0]           div_q;
	logic [SW-1:0]           sq_q;
	logic [DW-1:0]           rem_q;
	logic [CW-1:0]           cnt_q;
	logic                    res_q;
	logic                    is_prime_q;

	logic [DW:0]   trial;
	logic          fits;
	logic [DW-1:0] rem_nxt;

	assign trial   = {rem_q, sh_q[NUMBER_WIDTH-1]};
	assign fits    = trial >= {1'b0, div_q};
	assign rem_nxt = fits ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];

	assign sts.below_two = num_q < NUMBER_WIDTH'(2);
	assign sts.sq_gt     = sq_q > SW'(num_q);
	assign sts.cnt_last  = cnt_q == CW'(NUMBER_WIDTH - 1);
	assign sts.rem_zero  = rem_nxt == '0;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= number;
			div_q <= DW'(2);
			sq_q  <= SW'(4);
		end else if (cmd.advance) begin
			div_q <= div_q + DW'(1);
			// (d+1)^2 = d^2 + 2d + 1
			sq_q  <= sq_q + SW'({div_q, 1'b1});
		end
		if (cmd.init_div) begin
			sh_q  <= num_q;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			sh_q  <= {sh_q[NUMBER_WIDTH-2:0], 1'b0};
			rem_q <= rem_nxt;
			cnt_q <= cnt_q + CW'(1);
		end
		if (cmd.set_res) begin
			res_q <= cmd.res_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_prime_q <= 1'b0;
		end else if (cmd.publish) begin
			is_prime_q <= res_q;
		end
	end

	assign is_prime = is_prime_q;

endmodule

// ===== rtl/core/tdpt_ctrl.sv =====
// ---------------------------------------------------------------------------
// tdpt_ctrl
// Sequencer for the trial division search and the output beat handshake.
// ---------------------------------------------------------------------------
`include "trial_division_prime_test_defines.svh"

module tdpt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  tdpt_pkg::sts_t sts,
	output tdpt_pkg::cmd_t cmd
);
	import tdpt_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   pub_ok;

	assign pub_ok   = !out_valid_q || out_ready;
	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.below_two || sts.sq_gt) state_nxt = ST_DONE;
				else                            state_nxt = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (sts.cnt_last) state_nxt = sts.rem_zero ? ST_DONE : ST_CHECK;
			end
			ST_DONE: begin
				if (pub_ok) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_CHECK: begin
				if (sts.below_two) begin
					cmd.set_res = 1'b1;
					cmd.res_val = 1'b0;
				end else if (sts.sq_gt) begin
					cmd.set_res = 1'b1;
					cmd.res_val = 1'b1;
				end else begin
					cmd.init_div = 1'b1;
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (sts.cnt_last) begin
					if (sts.rem_zero) begin
						cmd.set_res = 1'b1;
						cmd.res_val = 1'b0;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			ST_DONE: begin
				cmd.publish = pub_ok;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.publish)    out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`TDPT_ASSERT_NEXT(a_load_to_check, in_valid && in_ready, state_q == ST_CHECK)
	`TDPT_ASSERT_NEXT(a_small_done, state_q == ST_CHECK && sts.below_two, state_q == ST_DONE)
	`TDPT_ASSERT_NEXT(a_publish, state_q == ST_DONE && !out_valid_q,
		out_valid_q && state_q == ST_IDLE)

endmodule

// ===== rtl/core/trial_division_prime_test.sv =====
// ---------------------------------------------------------------------------
// trial_division_prime_test
// Reports whether an unsigned number is prime, by trial division.
// ---------------------------------------------------------------------------
// Input channel: number with in_valid/in_ready; a beat is taken only while
// the block is idle. Output channel: is_prime with out_valid/out_ready, one
// result beat per input beat, held in an output register.
// Candidate divisors run 2, 3, ... while divisor squared does not exceed the
// number; the search stops at the first divisor leaving remainder zero.
// Numbers below two report 0 without any division.
// A number below 4 needs no division. Otherwise each trial divisor takes one
// bound check in ST_CHECK plus a bit-serial remainder over all NUMBER_WIDTH
// bits of the number in ST_DIVIDE; a zero remainder ends the search.
// After each verdict the block returns to idle to take the next beat.
// The next item is accepted as soon as the verdict enters the output register,
// even if the previous beat is still waiting; a new verdict then waits in
// the controller until the receiver takes the old one.
// Reset (arst_n low) clears the controller and out_valid; the block comes
// up idle with in_ready high.
// ---------------------------------------------------------------------------
module trial_division_prime_test #(
	parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [NUMBER_WIDTH-1:0] number,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    is_prime
);
	import tdpt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tdpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tdpt_datapath #(
		.NUMBER_WIDTH (NUMBER_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.number   (number),
		.cmd      (cmd),
		.sts      (sts),
		.is_prime (is_prime)
	);

endmodule
